/* design/fbc_pkg.sv */
// Package for the face box clip and select block with cheek region.
// Holds field widths, register indexes, reset values and cheek ratios.
// Used by every module of the block; depends on nothing.
package fbc_pkg;

  localparam int COORD_BITS_DEFAULT = 13;
  localparam int FIELD_BITS = 16;
  localparam int CLIP_BITS = FIELD_BITS + 2;

  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam logic [FIELD_BITS-1:0] FRAME_WIDTH_RESET = 16'd640;
  localparam logic [FIELD_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

  localparam int CHEEK_W_NUM = 3;
  localparam int CHEEK_W_DEN = 5;
  localparam int CHEEK_H_NUM = 2;
  localparam int CHEEK_H_DEN = 5;
  localparam int CHEEK_Y_NUM = 11;
  localparam int CHEEK_Y_DEN = 20;

endpackage

/* design/fbc_select.sv */
// Clips one box to the frame and keeps the largest clipped box of the list.
// Holds the running selection and a register with the selection after each box.
// Depends on fbc_pkg.
module fbc_select #(
  parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic                                  box_present,
  input  logic signed [fbc_pkg::FIELD_BITS-1:0] box_x,
  input  logic signed [fbc_pkg::FIELD_BITS-1:0] box_y,
  input  logic signed [fbc_pkg::FIELD_BITS-1:0] box_w,
  input  logic signed [fbc_pkg::FIELD_BITS-1:0] box_h,
  input  logic                                  list_end,
  input  logic [COORD_BITS-1:0]                 frame_width,
  input  logic [COORD_BITS-1:0]                 frame_height,
  output logic                                  sel_found,
  output logic [COORD_BITS-1:0]                 sel_left,
  output logic [COORD_BITS-1:0]                 sel_top,
  output logic [COORD_BITS-1:0]                 sel_width,
  output logic [COORD_BITS-1:0]                 sel_height,
  output logic                                  sel_final
);

  localparam int SW = fbc_pkg::CLIP_BITS;
  localparam int AW = 2 * COORD_BITS;

  logic signed [SW-1:0] x, y, w, h, fw, fh;
  logic signed [SW-1:0] l, t, r, b, r_raw, b_raw;
  logic                 usable, take;
  logic [COORD_BITS-1:0] cw, ch;
  logic [AW-1:0]        area;

  logic                  have_best;
  logic [COORD_BITS-1:0] best_left, best_top, best_width, best_height;
  logic [AW-1:0]         best_area;

  logic                  have_best_next;
  logic [COORD_BITS-1:0] best_left_next, best_top_next, best_width_next, best_height_next;
  logic [AW-1:0]         best_area_next;

  always_comb begin
    x = SW'(box_x);
    y = SW'(box_y);
    w = SW'(box_w);
    h = SW'(box_h);
    fw = $signed(SW'(frame_width));
    fh = $signed(SW'(frame_height));
    l = (x > 0) ? x : '0;
    t = (y > 0) ? y : '0;
    r_raw = x + w;
    b_raw = y + h;
    r = (r_raw > fw) ? fw : r_raw;
    b = (b_raw > fh) ? fh : b_raw;
    usable = box_present && (fw > 0) && (fh > 0) && (w > 0) && (h > 0) &&
             (r > l) && (b > t);
    cw = COORD_BITS'(r - l);
    ch = COORD_BITS'(b - t);
    area = AW'(cw) * AW'(ch);
    take = usable && (!have_best || (area > best_area));

    have_best_next = have_best;
    best_left_next = best_left;
    best_top_next = best_top;
    best_width_next = best_width;
    best_height_next = best_height;
    best_area_next = best_area;
    if (take) begin
      have_best_next = 1'b1;
      best_left_next = COORD_BITS'(l);
      best_top_next = COORD_BITS'(t);
      best_width_next = cw;
      best_height_next = ch;
      best_area_next = area;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      best_left <= '0;
      best_top <= '0;
      best_width <= '0;
      best_height <= '0;
      best_area <= '0;
      sel_found <= 1'b0;
      sel_final <= 1'b0;
    end else if (load) begin
      sel_found <= have_best_next;
      sel_final <= list_end;
      // The selection is forgotten once the last box of a list is reported.
      if (list_end) begin
        have_best <= 1'b0;
        best_left <= '0;
        best_top <= '0;
        best_width <= '0;
        best_height <= '0;
        best_area <= '0;
      end else begin
        have_best <= have_best_next;
        best_left <= best_left_next;
        best_top <= best_top_next;
        best_width <= best_width_next;
        best_height <= best_height_next;
        best_area <= best_area_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sel_left <= best_left_next;
      sel_top <= best_top_next;
      sel_width <= best_width_next;
      sel_height <= best_height_next;
    end
  end

endmodule

/* design/fbc_cheek.sv */
// Derives the cheek region from a selected face box and registers the result.
// Divisions by constants use reciprocal multiplication; depends on fbc_pkg.
module fbc_cheek #(
  parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  sel_found,
  input  logic [COORD_BITS-1:0] sel_left,
  input  logic [COORD_BITS-1:0] sel_top,
  input  logic [COORD_BITS-1:0] sel_width,
  input  logic [COORD_BITS-1:0] sel_height,
  input  logic                  sel_final,
  output logic                  face_found,
  output logic [COORD_BITS-1:0] face_x,
  output logic [COORD_BITS-1:0] face_y,
  output logic [COORD_BITS-1:0] face_w,
  output logic [COORD_BITS-1:0] face_h,
  output logic [COORD_BITS-1:0] cheek_x,
  output logic [COORD_BITS-1:0] cheek_y,
  output logic [COORD_BITS-1:0] cheek_w,
  output logic [COORD_BITS-1:0] cheek_h,
  output logic                  selection_final
);

  // Each quotient uses m = ceil(2^s / d) with s = n + ceil(log2 d), exact for n-bit dividends.
  localparam int WN = COORD_BITS + $clog2(fbc_pkg::CHEEK_W_NUM + 1);
  localparam int WS = WN + $clog2(fbc_pkg::CHEEK_W_DEN);
  localparam longint WM = ((longint'(1) << WS) + fbc_pkg::CHEEK_W_DEN - 1) /
                          fbc_pkg::CHEEK_W_DEN;
  localparam int HN = COORD_BITS + $clog2(fbc_pkg::CHEEK_H_NUM + 1);
  localparam int HS = HN + $clog2(fbc_pkg::CHEEK_H_DEN);
  localparam longint HM = ((longint'(1) << HS) + fbc_pkg::CHEEK_H_DEN - 1) /
                          fbc_pkg::CHEEK_H_DEN;
  localparam int YN = COORD_BITS + $clog2(fbc_pkg::CHEEK_Y_NUM + 1);
  localparam int YS = YN + $clog2(fbc_pkg::CHEEK_Y_DEN);
  localparam longint YM = ((longint'(1) << YS) + fbc_pkg::CHEEK_Y_DEN - 1) /
                          fbc_pkg::CHEEK_Y_DEN;

  logic [WN-1:0]    wn;
  logic [HN-1:0]    hn;
  logic [YN-1:0]    yn;
  logic [WN+WS-1:0] wp;
  logic [HN+HS-1:0] hp;
  logic [YN+YS-1:0] yp;
  logic [COORD_BITS-1:0] rw_raw, rh_raw, yq, rw, rh, cx, cy;

  always_comb begin
    wn = WN'(sel_width) * WN'(fbc_pkg::CHEEK_W_NUM);
    hn = HN'(sel_height) * HN'(fbc_pkg::CHEEK_H_NUM);
    yn = YN'(sel_height) * YN'(fbc_pkg::CHEEK_Y_NUM);
    wp = (WN+WS)'(wn) * WM[WN+WS-1:0];
    hp = (HN+HS)'(hn) * HM[HN+HS-1:0];
    yp = (YN+YS)'(yn) * YM[YN+YS-1:0];
    rw_raw = wp[WS +: COORD_BITS];
    rh_raw = hp[HS +: COORD_BITS];
    yq = yp[YS +: COORD_BITS];
    rw = (rw_raw == '0) ? COORD_BITS'(1) : rw_raw;
    rh = (rh_raw == '0) ? COORD_BITS'(1) : rh_raw;
    cx = sel_left + ((sel_width - rw) >> 1);
    cy = sel_top + yq;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      face_found <= sel_found;
      selection_final <= sel_final;
      if (sel_found) begin
        face_x <= sel_left;
        face_y <= sel_top;
        face_w <= sel_width;
        face_h <= sel_height;
        cheek_x <= cx;
        cheek_y <= cy;
        cheek_w <= rw;
        cheek_h <= rh;
      end else begin
        face_x <= '0;
        face_y <= '0;
        face_w <= '0;
        face_h <= '0;
        cheek_x <= '0;
        cheek_y <= '0;
        cheek_w <= '0;
        cheek_h <= '0;
      end
    end
  end

endmodule

/* design/face_box_clip_select_cheek_roi_core.sv */
// Top level of the face box clip and select block with cheek region.
// Holds the frame registers, the input register and the pipeline control.
// Depends on fbc_pkg, fbc_select and fbc_cheek.
//
// Usage: face boxes enter on the input channel, one transaction per box or
// per empty terminator; list_end marks the last transaction of a frame's list.
// Every input transaction yields exactly one output transaction with the
// largest clipped box seen so far in the list and its cheek region.
// The frame size is set through the configuration channel (index 0 width,
// index 1 height), which is always ready; write it only while the block is idle.
// An accepted box passes the input, selection and output registers in order.
// Throughput: one transaction per cycle while the receiver does not stall, set
// by the area compare against the running best, which feeds the next box.
// Three stages (input, selection, output) each hold one transaction; when the
// receiver stalls, the stages fill up and in_ready drops only once all three
// are full. Nothing is lost or repeated.
// Reset empties the pipeline, clears the selection and sets the frame to
// 640 by 480. The selection also clears after each list_end transaction.
module face_box_clip_select_cheek_roi_core #(
  parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fbc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  box_present,
  input  logic signed [fbc_pkg::FIELD_BITS-1:0] box_x,
  input  logic signed [fbc_pkg::FIELD_BITS-1:0] box_y,
  input  logic signed [fbc_pkg::FIELD_BITS-1:0] box_w,
  input  logic signed [fbc_pkg::FIELD_BITS-1:0] box_h,
  input  logic                                  list_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  face_found,
  output logic [COORD_BITS-1:0]                 face_x,
  output logic [COORD_BITS-1:0]                 face_y,
  output logic [COORD_BITS-1:0]                 face_w,
  output logic [COORD_BITS-1:0]                 face_h,
  output logic [COORD_BITS-1:0]                 cheek_x,
  output logic [COORD_BITS-1:0]                 cheek_y,
  output logic [COORD_BITS-1:0]                 cheek_w,
  output logic [COORD_BITS-1:0]                 cheek_h,
  output logic                                  selection_final
);

  logic [COORD_BITS-1:0] frame_width, frame_height;

  logic v1, v2, v3;
  logic r1, r2, r3;
  logic in_fire, load2, load3;

  logic                                  in_present, in_end;
  logic signed [fbc_pkg::FIELD_BITS-1:0] in_x, in_y, in_w, in_h;

  logic                  sel_found, sel_final;
  logic [COORD_BITS-1:0] sel_left, sel_top, sel_width, sel_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= fbc_pkg::FRAME_WIDTH_RESET[COORD_BITS-1:0];
      frame_height <= fbc_pkg::FRAME_HEIGHT_RESET[COORD_BITS-1:0];
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fbc_pkg::REG_FRAME_WIDTH: frame_width <= cfg_data;
        fbc_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    r3 = !v3 || out_ready;
    r2 = !v2 || r3;
    r1 = !v1 || r2;
    in_ready = r1;
    in_fire = in_valid && r1;
    load2 = v1 && r2;
    load3 = v2 && r3;
    out_valid = v3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_fire || (v1 && !r2);
      v2 <= load2 || (v2 && !r3);
      v3 <= load3 || (v3 && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_present <= box_present;
      in_x <= box_x;
      in_y <= box_y;
      in_w <= box_w;
      in_h <= box_h;
      in_end <= list_end;
    end
  end

  fbc_select #(
    .COORD_BITS(COORD_BITS)
  ) u_select (
    .clk          (clk),
    .rst          (rst),
    .load         (load2),
    .box_present  (in_present),
    .box_x        (in_x),
    .box_y        (in_y),
    .box_w        (in_w),
    .box_h        (in_h),
    .list_end     (in_end),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .sel_found    (sel_found),
    .sel_left     (sel_left),
    .sel_top      (sel_top),
    .sel_width    (sel_width),
    .sel_height   (sel_height),
    .sel_final    (sel_final)
  );

  fbc_cheek #(
    .COORD_BITS(COORD_BITS)
  ) u_cheek (
    .clk             (clk),
    .load            (load3),
    .sel_found       (sel_found),
    .sel_left        (sel_left),
    .sel_top         (sel_top),
    .sel_width       (sel_width),
    .sel_height      (sel_height),
    .sel_final       (sel_final),
    .face_found      (face_found),
    .face_x          (face_x),
    .face_y          (face_y),
    .face_w          (face_w),
    .face_h          (face_h),
    .cheek_x         (cheek_x),
    .cheek_y         (cheek_y),
    .cheek_w         (cheek_w),
    .cheek_h         (cheek_h),
    .selection_final (selection_final)
  );

endmodule
